// ----- rtl/core/swd_pkg.sv -----
// Shared constants for the sigmoid-with-derivative datapath.
`timescale 1ns / 1ps
package swd_pkg;

  // Working fixed-point format of the exponential term (Q30)
  localparam int WORK_BITS = 30;

  // Width of the exponential term: holds the saturation value 2^62
  localparam int VW = 63;

  // Squaring ranges: exact below 2^32, truncated below 2^46, saturated above
  localparam int SMALL_LIM_BITS = 32;
  localparam int MID_LIM_BITS   = 46;
  localparam int HALF_SHIFT     = 15;

  localparam logic [VW-1:0] SAT_VAL   = VW'(1) << 62;
  localparam logic [VW-1:0] WORK_ONE  = VW'(1) << WORK_BITS;
  localparam logic [64:0]   SQ_ROUND  = 65'(1) << (WORK_BITS - 1);

endpackage

// ----- rtl/core/swd_square_cell.sv -----
// One squaring cell of the exponential chain: multiply stage then rescale stage.
`timescale 1ns / 1ps
module swd_square_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [swd_pkg::VW-1:0]  v_i,
  output logic                    valid_o,
  output logic [swd_pkg::VW-1:0]  v_o
);

  typedef enum logic [1:0] {
    CLS_SMALL,
    CLS_MID,
    CLS_SAT
  } cls_e;

  cls_e        cls_d, cls_q;
  logic [31:0] op;
  logic [63:0] prod_d, prod_q;
  logic [64:0] rnd;
  logic [swd_pkg::VW-1:0] v_d, v_q;
  logic        vld1_q, vld2_q;

  // range classification and multiplier operand
  always_comb begin
    if (v_i[swd_pkg::VW-1:swd_pkg::SMALL_LIM_BITS] == '0) begin
      cls_d = CLS_SMALL;
      op    = v_i[31:0];
    end else if (v_i[swd_pkg::VW-1:swd_pkg::MID_LIM_BITS] == '0) begin
      cls_d = CLS_MID;
      op    = {1'b0, v_i[swd_pkg::MID_LIM_BITS-1:swd_pkg::HALF_SHIFT]};
    end else begin
      cls_d = CLS_SAT;
      op    = '0;
    end
    prod_d = {32'd0, op} * {32'd0, op};
  end

  // rescale the product back to Q30
  always_comb begin
    rnd = {1'b0, prod_q} + swd_pkg::SQ_ROUND;
    unique case (cls_q)
      CLS_SMALL: v_d = swd_pkg::VW'(rnd >> swd_pkg::WORK_BITS);
      CLS_MID:   v_d = swd_pkg::VW'(prod_q);
      default:   v_d = swd_pkg::SAT_VAL;
    endcase
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cls_q  <= cls_d;
      prod_q <= prod_d;
      v_q    <= v_d;
    end
  end

  assign valid_o = vld2_q;
  assign v_o     = v_q;

endmodule

// ----- rtl/core/swd_div_cell.sv -----
// One restoring-division cell: decides a single quotient bit.
`timescale 1ns / 1ps
module swd_div_cell #(
  parameter int FRAC_BITS = 16,
  parameter int BIT       = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [FRAC_BITS+63:0]   rem_i,
  input  logic [swd_pkg::VW-1:0]  d_i,
  input  logic [FRAC_BITS:0]      q_i,
  output logic                    valid_o,
  output logic [FRAC_BITS+63:0]   rem_o,
  output logic [swd_pkg::VW-1:0]  d_o,
  output logic [FRAC_BITS:0]      q_o
);

  localparam int RW = FRAC_BITS + 64;

  logic [RW-1:0]          dsh, rem_d, rem_q;
  logic                   geq;
  logic [FRAC_BITS:0]     q_d, q_q;
  logic [swd_pkg::VW-1:0] d_q;
  logic                   vld_q;

  // trial subtract of the shifted divisor
  always_comb begin
    dsh   = RW'(d_i) << BIT;
    geq   = rem_i >= dsh;
    rem_d = geq ? rem_i - dsh : rem_i;
    q_d   = q_i;
    q_d[BIT] = geq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      d_q   <= d_i;
      q_q   <= q_d;
    end
  end

  assign valid_o = vld_q;
  assign rem_o   = rem_q;
  assign d_o     = d_q;
  assign q_o     = q_q;

endmodule

// ----- rtl/core/sigmoid_with_derivative_unit.sv -----
// Top level: streaming sigmoid / sigmoid-derivative unit.
`timescale 1ns / 1ps
// Usage:
//  Input channel: x_value_i (signed, FRAC_BITS fraction bits) with in_valid_i;
//  a transaction completes when in_valid_i is high and in_stall_o is low.
//  Output channel: y_value_o (unsigned, FRAC_BITS fraction bits) with
//  out_valid_o; the receiver holds out_stall_i high to stall it.
//  derivative_mode_we_i writes derivative_mode_i: 0 selects s, 1 selects s*(1-s).
//  Write it only while the pipeline is empty.
//  Pipeline: one base stage, two stages per squaring cell, a divider set-up
//  stage, FRAC_BITS+1 restoring-division cells and two output stages.
//  Throughput: one transaction per cycle while no valid result is stalled;
//  every stage moves together, all enabled by one shared advance signal.
//  When the output is valid and stalled, the whole chain freezes and
//  in_stall_o rises in the same cycle; results are never lost or repeated.
//  Reset empties the pipeline and clears derivative_mode to 0.
module sigmoid_with_derivative_unit #(
  parameter int FRAC_BITS    = 16,
  parameter int SQUARE_STEPS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               derivative_mode_we_i,
  input  logic               derivative_mode_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] x_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FRAC_BITS:0] y_value_o
);

  localparam int VW     = swd_pkg::VW;
  localparam int RW     = FRAC_BITS + 64;
  localparam int BW     = (FRAC_BITS + 12 > 34) ? FRAC_BITS + 12 : 34;
  localparam int BASE_Q = FRAC_BITS + 10;
  localparam logic signed [BW-1:0] BASE_ONE = BW'(1) << BASE_Q;
  localparam logic [FRAC_BITS:0]   ONE      = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [RW-1:0] NUM_CONST =
      (RW'(1) << (FRAC_BITS + swd_pkg::WORK_BITS)) +
      (RW'(1) << (swd_pkg::WORK_BITS - 1));
  localparam logic [2*FRAC_BITS+1:0] D_ROUND = (2*FRAC_BITS+2)'(1) << (FRAC_BITS - 1);
  localparam logic [FRAC_BITS:0]     D_MAX   = (FRAC_BITS+1)'(1) << (FRAC_BITS - 2);

  logic adv;
  logic mode_q;

  // global advance: the chain moves unless a held result is stalled
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (derivative_mode_we_i) begin
      mode_q <= derivative_mode_i;
    end
  end

  // base stage: b = 1 - x/1024, clamped at zero, moved to Q30
  logic signed [BW-1:0] b_s;
  logic [BW-1:0]        b_pos;
  logic [VW-1:0]        base_d, base_q;
  logic                 base_vld_q;

  always_comb begin
    b_s   = BASE_ONE - BW'(x_value_i);
    b_pos = b_s[BW-1] ? '0 : b_s;
  end

  if (BASE_Q <= swd_pkg::WORK_BITS) begin : g_base_up
    assign base_d = VW'(b_pos) << (swd_pkg::WORK_BITS - BASE_Q);
  end else begin : g_base_dn
    assign base_d = VW'(b_pos >> (BASE_Q - swd_pkg::WORK_BITS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_vld_q <= 1'b0;
    end else if (adv) begin
      base_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      base_q <= base_d;
    end
  end

  // chain of squaring cells
  logic [VW-1:0] sq_v   [SQUARE_STEPS+1];
  logic          sq_vld [SQUARE_STEPS+1];

  assign sq_v[0]   = base_q;
  assign sq_vld[0] = base_vld_q;

  for (genvar k = 0; k < SQUARE_STEPS; k++) begin : g_sq
    swd_square_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sq_vld[k]),
      .v_i     (sq_v[k]),
      .valid_o (sq_vld[k+1]),
      .v_o     (sq_v[k+1])
    );
  end

  // divider set-up: d = 1 + e, numerator = 2^(F+30) + d/2
  logic [VW-1:0] dv_d_q;
  logic [RW-1:0] dv_n_q;
  logic          dv_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= 1'b0;
    end else if (adv) begin
      dv_vld_q <= sq_vld[SQUARE_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_d_q <= sq_v[SQUARE_STEPS] + swd_pkg::WORK_ONE;
      dv_n_q <= NUM_CONST + RW'(sq_v[SQUARE_STEPS] >> 1);
    end
  end

  // chain of division cells, quotient MSB first
  logic [RW-1:0]      dc_rem [FRAC_BITS+2];
  logic [VW-1:0]      dc_d   [FRAC_BITS+2];
  logic [FRAC_BITS:0] dc_q   [FRAC_BITS+2];
  logic               dc_vld [FRAC_BITS+2];

  assign dc_rem[0] = dv_n_q;
  assign dc_d[0]   = dv_d_q;
  assign dc_q[0]   = '0;
  assign dc_vld[0] = dv_vld_q;

  for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_div
    swd_div_cell #(
      .FRAC_BITS (FRAC_BITS),
      .BIT       (FRAC_BITS - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dc_vld[k]),
      .rem_i   (dc_rem[k]),
      .d_i     (dc_d[k]),
      .q_i     (dc_q[k]),
      .valid_o (dc_vld[k+1]),
      .rem_o   (dc_rem[k+1]),
      .d_o     (dc_d[k+1]),
      .q_o     (dc_q[k+1])
    );
  end

  // derivative product s*(1-s)
  logic [FRAC_BITS:0]     s_c, s_q;
  logic [2*FRAC_BITS+1:0] p_q, rnd;
  logic                   mul_vld_q;
  logic [FRAC_BITS:0]     y_d, y_q;
  logic                   y_vld_q;

  assign s_c = (dc_q[FRAC_BITS+1] > ONE) ? ONE : dc_q[FRAC_BITS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q <= s_c;
      p_q <= (2*FRAC_BITS+2)'(s_c) * (2*FRAC_BITS+2)'(ONE - s_c);
      y_q <= y_d;
    end
  end

  // output select and rounding
  always_comb begin
    rnd = p_q + D_ROUND;
    y_d = mode_q ? (FRAC_BITS+1)'(rnd >> FRAC_BITS) : s_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      y_vld_q   <= 1'b0;
    end else if (adv) begin
      mul_vld_q <= dc_vld[FRAC_BITS+1];
      y_vld_q   <= mul_vld_q;
    end
  end

  assign out_valid_o = y_vld_q;
  assign y_value_o   = y_q;

  // checks
  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> y_value_o <= ONE)
    else $error("result above one");

  a_deriv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_q |-> y_value_o <= D_MAX)
    else $error("derivative above one quarter");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dc_vld[FRAC_BITS+1] |-> dc_q[FRAC_BITS+1] <= ONE)
    else $error("division quotient out of range");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(mul_vld_q) && $stable(s_q))
    else $error("pipeline moved during output stall");

endmodule
